// ===== rtl/sdq_pkg.sv =====
`default_nettype none

package sdq_pkg;

    localparam int GAIN_W      = 17;
    localparam int GAIN_FRAC   = 16;
    localparam int NOISE_W     = 16;
    localparam int NOISE_FRAC  = 12;
    localparam int BD_W        = 6;
    localparam int BD_MIN      = 1;
    localparam int BD_MAX      = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = GAIN_W;
    localparam int N_STG       = 5;
    localparam int NOISE_SHIFT = NOISE_FRAC + GAIN_FRAC;

    localparam logic [CFG_IDX_W-1:0] REG_BIT_DEPTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DITHER_ON   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUANTIZE_ON = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_ONLY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_DITHER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_GAIN  = 3'd7;

    localparam logic [BD_W-1:0]   BD_RESET   = 6'd16;
    localparam logic [GAIN_W-1:0] GAIN_UNITY = 17'd65536;

    typedef struct packed {
        logic [BD_W-1:0]   bit_depth;
        logic              dither_on;
        logic              quantize_on;
        logic              error_only;
        logic              auto_dither;
        logic [GAIN_W-1:0] input_gain;
        logic [GAIN_W-1:0] output_gain;
        logic [GAIN_W-1:0] noise_gain;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/sdq_cfg.sv =====
`default_nettype none

module sdq_cfg
    import sdq_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_BIT_DEPTH:   n_cfg.bit_depth   = i_cfg_data[BD_W-1:0];
                REG_DITHER_ON:   n_cfg.dither_on   = i_cfg_data[0];
                REG_QUANTIZE_ON: n_cfg.quantize_on = i_cfg_data[0];
                REG_ERROR_ONLY:  n_cfg.error_only  = i_cfg_data[0];
                REG_AUTO_DITHER: n_cfg.auto_dither = i_cfg_data[0];
                REG_INPUT_GAIN:  n_cfg.input_gain  = i_cfg_data[GAIN_W-1:0];
                REG_OUTPUT_GAIN: n_cfg.output_gain = i_cfg_data[GAIN_W-1:0];
                REG_NOISE_GAIN:  n_cfg.noise_gain  = i_cfg_data[GAIN_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_depth   <= BD_RESET;
            r_cfg.dither_on   <= 1'b1;
            r_cfg.quantize_on <= 1'b0;
            r_cfg.error_only  <= 1'b0;
            r_cfg.auto_dither <= 1'b0;
            r_cfg.input_gain  <= GAIN_UNITY;
            r_cfg.output_gain <= GAIN_UNITY;
            r_cfg.noise_gain  <= GAIN_UNITY;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // The datapath sees the bit depth already limited to its legal range.
    always_comb begin
        o_cfg = r_cfg;
        if (r_cfg.bit_depth < BD_W'(BD_MIN)) begin
            o_cfg.bit_depth = BD_W'(BD_MIN);
        end else if (r_cfg.bit_depth > BD_W'(BD_MAX)) begin
            o_cfg.bit_depth = BD_W'(BD_MAX);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sdq_pipe_ctl.sv =====
`default_nettype none

module sdq_pipe_ctl
    import sdq_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_in_valid,
    input  wire logic   i_out_stall,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output logic [N_STG-1:0] o_en
);

    logic [N_STG-1:0] r_vld;
    logic [N_STG-1:0] n_vld;
    logic [N_STG-1:0] en;

    // A stage loads when it is empty or when the stage after it moves on.
    always_comb begin
        en[N_STG-1] = !r_vld[N_STG-1] || !i_out_stall;
        for (int s = N_STG - 2; s >= 0; s--) begin
            en[s] = !r_vld[s] || en[s+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (en[0]) begin
            n_vld[0] = i_in_valid;
        end
        for (int s = 1; s < N_STG; s++) begin
            if (en[s]) begin
                n_vld[s] = r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_en        = en;
    assign o_in_stall  = !en[0];
    assign o_out_valid = r_vld[N_STG-1];

endmodule

`default_nettype wire

// ===== rtl/sdq_channel.sv =====
`default_nettype none

module sdq_channel
    import sdq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 32,
    parameter int FRAC_BITS    = 28
) (
    input  wire logic                           i_clk,
    input  wire logic [N_STG-1:0]               i_en,
    input  wire t_cfg                           i_cfg,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  wire logic signed [NOISE_W-1:0]      i_noise,
    output logic signed [SAMPLE_WIDTH-1:0]      o_out
);

    localparam int W      = SAMPLE_WIDTH;
    localparam int PW     = W + GAIN_W + 1;
    localparam int VW     = PW - GAIN_FRAC;
    localparam int NPW    = NOISE_W + GAIN_W + 1;
    localparam int WIDE_W = NPW + FRAC_BITS;
    localparam int AW     = FRAC_BITS + 5;
    localparam int SUM_W  = ((VW > AW) ? VW : AW) + 1;
    localparam int SH_W   = BD_W + 1;
    localparam int KW     = $clog2(FRAC_BITS + 2);
    localparam int CW     = ((KW > BD_W) ? KW : BD_W) + 1;

    localparam logic signed [SUM_W-1:0] SUM_HI = {{(SUM_W-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_LO = {{(SUM_W-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [VW-1:0]    OUT_HI = {{(VW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [VW-1:0]    OUT_LO = {{(VW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [W-1:0]     ONE    = W'(1) << FRAC_BITS;

    // Stage 1: input gain and noise gain products.
    logic signed [PW-1:0]  r_vprod;
    logic signed [NPW-1:0] r_nprod;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_vprod <= PW'(i_sample) * $signed({{(PW-GAIN_W){1'b0}}, i_cfg.input_gain});
            r_nprod <= NPW'(i_noise) * $signed({{(NPW-GAIN_W){1'b0}}, i_cfg.noise_gain});
        end
    end

    // Stage 2: scale the noise to the bit depth, add it if dithering and saturate.
    logic signed [VW-1:0]     v2;
    logic signed [WIDE_W-1:0] nwide;
    logic [SH_W-1:0]          nshift;
    logic signed [AW-1:0]     nadd;
    logic                     dith;
    logic signed [SUM_W-1:0]  sum2;
    logic signed [W-1:0]      r_s2;

    always_comb begin
        v2     = r_vprod[PW-1:GAIN_FRAC];
        nwide  = $signed({r_nprod, {FRAC_BITS{1'b0}}});
        nshift = SH_W'(NOISE_SHIFT) + SH_W'(i_cfg.bit_depth);
        nadd   = AW'(nwide >>> nshift);
        dith   = i_cfg.dither_on && !(i_cfg.auto_dither && (v2 == '0));
        sum2   = SUM_W'(v2) + (dith ? SUM_W'(nadd) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            if (sum2 > SUM_HI) begin
                r_s2 <= SUM_HI[W-1:0];
            end else if (sum2 < SUM_LO) begin
                r_s2 <= SUM_LO[W-1:0];
            end else begin
                r_s2 <= sum2[W-1:0];
            end
        end
    end

    // Stage 3: if quantising, clamp to the unit range and split at the grid step.
    logic signed [W-1:0] clamp3;
    logic [CW-1:0]       bd3;
    logic [CW-1:0]       k3;
    logic [W-1:0]        mask3;
    logic signed [W-1:0] r_s3;

    always_comb begin
        if (r_s2 > ONE) begin
            clamp3 = ONE;
        end else if (r_s2 < -ONE) begin
            clamp3 = -ONE;
        end else begin
            clamp3 = r_s2;
        end
        bd3   = CW'(i_cfg.bit_depth);
        k3    = CW'(FRAC_BITS + 1) - bd3;
        mask3 = (bd3 <= CW'(FRAC_BITS)) ? ~({W{1'b1}} << k3) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            if (!i_cfg.quantize_on) begin
                r_s3 <= r_s2;
            end else if (i_cfg.error_only) begin
                r_s3 <= clamp3 & $signed(mask3);
            end else begin
                r_s3 <= clamp3 & $signed(~mask3);
            end
        end
    end

    // Stage 4: output gain product.
    logic signed [PW-1:0] r_oprod;

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_oprod <= PW'(r_s3) * $signed({{(PW-GAIN_W){1'b0}}, i_cfg.output_gain});
        end
    end

    // Stage 5: drop the gain fraction and saturate.
    logic signed [VW-1:0] v5;
    logic signed [W-1:0]  r_out;

    assign v5 = r_oprod[PW-1:GAIN_FRAC];

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            if (v5 > OUT_HI) begin
                r_out <= OUT_HI[W-1:0];
            end else if (v5 < OUT_LO) begin
                r_out <= OUT_LO[W-1:0];
            end else begin
                r_out <= v5[W-1:0];
            end
        end
    end

    assign o_out = r_out;

endmodule

`default_nettype wire

// ===== rtl/stereo_dither_quantizer_top.sv =====
// Channel  | Direction | Handshake                  | Word
// input    | in        | i_in_valid / o_in_stall    | two samples, two noise values
// output   | out       | o_out_valid / i_out_stall  | two processed samples
// config   | in        | i_cfg_valid / o_cfg_ready  | register index and data
//
// One stereo word enters per clock while the input is not stalled; each word passes
// through the five-stage datapath (input and noise gain products, the noise add, the
// quantiser, the output gain product and the output saturation).
// Synchronous active-low reset empties the pipeline and loads the register defaults.
// A stall at the output holds the last stage; earlier stages keep filling any bubbles,
// so the input is stalled only when every stage holds a word.
// Configuration writes are taken on every cycle.
`default_nettype none

module stereo_dither_quantizer_top
    import sdq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 32,
    parameter int FRAC_BITS    = 28
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_left_sample,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_right_sample,
    input  wire logic signed [NOISE_W-1:0]      i_left_noise,
    input  wire logic signed [NOISE_W-1:0]      i_right_noise,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]      o_left_out,
    output logic signed [SAMPLE_WIDTH-1:0]      o_right_out,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]           i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]          i_cfg_data
);

    t_cfg             cfg;
    logic [N_STG-1:0] en;

    sdq_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sdq_pipe_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_en        (en)
    );

    sdq_channel #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_left (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_cfg    (cfg),
        .i_sample (i_left_sample),
        .i_noise  (i_left_noise),
        .o_out    (o_left_out)
    );

    sdq_channel #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_right (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_cfg    (cfg),
        .i_sample (i_right_sample),
        .i_noise  (i_right_noise),
        .o_out    (o_right_out)
    );

endmodule

`default_nettype wire

// ===== rtl/sdq_checker.sv =====
`default_nettype none

module sdq_checker #(
    parameter int SAMPLE_WIDTH = 32
) (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_out_stall,
    input wire logic                    o_out_valid,
    input wire logic                    o_in_stall,
    input wire logic [SAMPLE_WIDTH-1:0] o_left_out,
    input wire logic [SAMPLE_WIDTH-1:0] o_right_out
);

    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word dropped while stalled");

    a_data_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_left_out) && $stable(o_right_out))
        else $error("output word changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_no_needless_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_stall |-> !o_in_stall)
        else $error("input stalled while the output drains");

endmodule

bind stereo_dither_quantizer_top sdq_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_sdq_checker (.*);

`default_nettype wire
